[design/set_assoc_cache_lru_sim_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the cache model RTL
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SACL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SACL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sacl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Types, codes and helpers of the set-associative cache LRU model.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 64;
    localparam int N_SETS       = 1 << MAX_SET_BITS;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int AGE_W        = 3;
    localparam int CNT_W        = 32;

    localparam int SB_W       = 4;
    localparam int BB_W       = 6;
    localparam int WAYS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // access kinds
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_FETCH  = 2'd3;

    // lookup outcomes
    localparam logic [1:0] OC_HIT   = 2'd0;
    localparam logic [1:0] OC_FILL  = 2'd1;
    localparam logic [1:0] OC_EVICT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

    typedef logic [ADDR_WIDTH-1:0] tag_t;

    typedef struct packed {
        logic             valid;
        tag_t             tag;
        logic [AGE_W-1:0] age;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             inv_found;
        logic [WAY_W-1:0] inv_way;
        logic [AGE_W-1:0] oldest;
        logic [WAY_W-1:0] victim;
    } scan_res_t;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? a : a + AGE_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

[design/sacl_tag_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_tag_store
// One row per set holding valid, tag and age of every way; registered read.
// ----------------------------------------------------------------------------
module sacl_tag_store (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [sacl_pkg::SET_W-1:0] rd_addr,
    output sacl_pkg::row_t             rd_data,
    input  logic                       wr_en,
    input  logic [sacl_pkg::SET_W-1:0] wr_addr,
    input  sacl_pkg::row_t             wr_data
);

    sacl_pkg::row_t mem [sacl_pkg::N_SETS];
    sacl_pkg::row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/sacl_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_scan
// Shared tag compare unit: looks at one way per step and keeps the hit,
// first free way and oldest way found so far.
// ----------------------------------------------------------------------------
module sacl_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       init,
    input  logic                       step,
    input  sacl_pkg::line_t            line,
    input  logic [sacl_pkg::WAY_W-1:0] way,
    input  sacl_pkg::tag_t             tag,
    output sacl_pkg::scan_res_t        res
);

    sacl_pkg::scan_res_t res_reg;
    sacl_pkg::scan_res_t res_next;

    always_comb
    begin
        res_next = res_reg;
        if (!res_reg.hit && line.valid && (line.tag == tag))
        begin
            res_next.hit     = 1'b1;
            res_next.hit_way = way;
        end
        if (!res_reg.inv_found && !line.valid)
        begin
            res_next.inv_found = 1'b1;
            res_next.inv_way   = way;
        end
        // later ways win ties
        if (line.valid && (line.age >= res_reg.oldest))
        begin
            res_next.oldest = line.age;
            res_next.victim = way;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (init)
        begin
            res_reg <= '0;
        end
        else if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[design/set_assoc_cache_lru_sim.sv]
`timescale 1ns / 1ps
// A lookup holds busy through one row read, one tag compare per way and one row write.
// Load or store: one lookup, the strobe in the first cycle with busy low; no new access is taken
// while busy is high; modify: two lookups, two strobes; fetch: no result.
// The single tag comparator scanning one way a cycle sets the rate; the receiver cannot stall.
// After reset a clearing pass sweeps all 256 sets of the tag store with busy high.
// Configuration writes are taken at any time through cfg_valid/cfg_ready.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Set-associative cache tag and LRU age model with hit/miss/eviction counters.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_sim_macros.svh"

module set_assoc_cache_lru_sim (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic [sacl_pkg::ADDR_WIDTH-1:0]     address,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    output logic [1:0]                          outcome,
    output logic [sacl_pkg::CNT_W-1:0]          hits_total,
    output logic [sacl_pkg::CNT_W-1:0]          misses_total,
    output logic [sacl_pkg::CNT_W-1:0]          evictions_total,
    output logic                                last_of_item
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    localparam int SET_W = sacl_pkg::SET_W;
    localparam int WAY_W = sacl_pkg::WAY_W;
    localparam int SH_W  = sacl_pkg::BB_W + 1;

    // control state
    logic [2:0]                  state_reg, state_next;
    logic [SET_W-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [WAY_W-1:0]            way_cnt_reg, way_cnt_next;
    logic                        pend_reg, pend_next;
    logic                        result_valid_reg, result_valid_next;
    logic [sacl_pkg::CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [sacl_pkg::CNT_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic [sacl_pkg::CNT_W-1:0]  evict_cnt_reg, evict_cnt_next;
    logic [sacl_pkg::SB_W-1:0]   set_bits_reg;
    logic [sacl_pkg::BB_W-1:0]   block_bits_reg;
    logic [sacl_pkg::WAYS_W-1:0] ways_reg;

    // payload
    logic [SET_W-1:0]            set_reg;
    sacl_pkg::tag_t              tag_reg;
    logic [WAY_W-1:0]            nw_m1_reg;
    logic [1:0]                  outcome_reg, outcome_next;
    logic                        last_reg, last_next;

    logic                        accept;
    logic [sacl_pkg::SB_W-1:0]   sb_eff;
    logic [SH_W-1:0]             shamt;
    logic [sacl_pkg::ADDR_WIDTH-1:0] addr_sh;
    logic [SET_W:0]              set_mask;
    logic [SET_W-1:0]            set_calc;
    sacl_pkg::tag_t              tag_calc;
    logic [WAY_W-1:0]            nw_m1_calc;

    logic                        rd_en;
    sacl_pkg::row_t              rd_row;
    logic                        wr_en;
    logic [SET_W-1:0]            wr_addr;
    sacl_pkg::row_t              wr_row;
    sacl_pkg::row_t              new_row;

    logic                        scan_init;
    logic                        scan_step;
    sacl_pkg::scan_res_t         scan_res;
    logic [sacl_pkg::AGE_W-1:0]  hit_age;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // ---------------- address split for the accepted beat ----------------
    always_comb
    begin
        sb_eff   = (set_bits_reg > sacl_pkg::SB_W'(sacl_pkg::MAX_SET_BITS))
                   ? sacl_pkg::SB_W'(sacl_pkg::MAX_SET_BITS) : set_bits_reg;
        shamt    = SH_W'(sb_eff) + SH_W'(block_bits_reg);
        addr_sh  = address >> block_bits_reg;
        set_mask = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
        set_calc = addr_sh[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_calc = (shamt >= SH_W'(sacl_pkg::ADDR_WIDTH)) ? '0 : (address >> shamt);
        if (ways_reg == '0)
        begin
            nw_m1_calc = '0;
        end
        else if (ways_reg > sacl_pkg::WAYS_W'(sacl_pkg::MAX_WAYS))
        begin
            nw_m1_calc = WAY_W'(sacl_pkg::MAX_WAYS - 1);
        end
        else
        begin
            nw_m1_calc = WAY_W'(ways_reg - sacl_pkg::WAYS_W'(1));
        end
    end

    // ---------------- tag store and shared compare unit ----------------
    sacl_tag_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (set_reg),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row)
    );

    sacl_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .init  (scan_init),
        .step  (scan_step),
        .line  (rd_row[way_cnt_reg]),
        .way   (way_cnt_reg),
        .tag   (tag_reg),
        .res   (scan_res)
    );

    assign hit_age = rd_row[scan_res.hit_way].age;

    // ---------------- row update: one small lane per way ----------------
    always_comb
    begin
        for (int j = 0; j < sacl_pkg::MAX_WAYS; j++)
        begin
            new_row[j] = rd_row[j];
            if (WAY_W'(j) <= nw_m1_reg)
            begin
                if (scan_res.hit)
                begin
                    if (rd_row[j].valid && (rd_row[j].age < hit_age))
                    begin
                        new_row[j].age = sacl_pkg::age_inc(rd_row[j].age);
                    end
                    if (WAY_W'(j) == scan_res.hit_way)
                    begin
                        new_row[j].age = '0;
                    end
                end
                else if (scan_res.inv_found)
                begin
                    if (rd_row[j].valid)
                    begin
                        new_row[j].age = sacl_pkg::age_inc(rd_row[j].age);
                    end
                    if (WAY_W'(j) == scan_res.inv_way)
                    begin
                        new_row[j].valid = 1'b1;
                        new_row[j].tag   = tag_reg;
                        new_row[j].age   = '0;
                    end
                end
                else
                begin
                    new_row[j].age = sacl_pkg::age_inc(rd_row[j].age);
                    if (WAY_W'(j) == scan_res.victim)
                    begin
                        new_row[j].tag = tag_reg;
                        new_row[j].age = '0;
                    end
                end
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        way_cnt_next      = way_cnt_reg;
        pend_next         = pend_reg;
        result_valid_next = 1'b0;
        hit_cnt_next      = hit_cnt_reg;
        miss_cnt_next     = miss_cnt_reg;
        evict_cnt_next    = evict_cnt_reg;
        outcome_next      = outcome_reg;
        last_next         = last_reg;
        rd_en             = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = set_reg;
        wr_row            = new_row;
        scan_init         = 1'b0;
        scan_step         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_row       = '0;
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(sacl_pkg::N_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (kind != sacl_pkg::KIND_FETCH))
                begin
                    pend_next  = (kind == sacl_pkg::KIND_MODIFY);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en        = 1'b1;
                scan_init    = 1'b1;
                way_cnt_next = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_step    = 1'b1;
                way_cnt_next = way_cnt_reg + WAY_W'(1);
                if (way_cnt_reg == nw_m1_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                wr_en             = 1'b1;
                result_valid_next = 1'b1;
                if (scan_res.hit)
                begin
                    hit_cnt_next = sacl_pkg::sat_inc(hit_cnt_reg);
                    outcome_next = sacl_pkg::OC_HIT;
                end
                else
                begin
                    miss_cnt_next = sacl_pkg::sat_inc(miss_cnt_reg);
                    if (scan_res.inv_found)
                    begin
                        outcome_next = sacl_pkg::OC_FILL;
                    end
                    else
                    begin
                        evict_cnt_next = sacl_pkg::sat_inc(evict_cnt_reg);
                        outcome_next   = sacl_pkg::OC_EVICT;
                    end
                end
                // modify repeats the lookup on the freshly written row
                last_next = !pend_reg;
                pend_next = 1'b0;
                state_next = pend_reg ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            way_cnt_reg      <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            hit_cnt_reg      <= '0;
            miss_cnt_reg     <= '0;
            evict_cnt_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            way_cnt_reg      <= way_cnt_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            hit_cnt_reg      <= hit_cnt_next;
            miss_cnt_reg     <= miss_cnt_next;
            evict_cnt_reg    <= evict_cnt_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= sacl_pkg::SB_W'(4);
            block_bits_reg <= sacl_pkg::BB_W'(4);
            ways_reg       <= sacl_pkg::WAYS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sacl_pkg::REG_SET_BITS:   set_bits_reg   <= cfg_data[sacl_pkg::SB_W-1:0];
                sacl_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg_data[sacl_pkg::BB_W-1:0];
                sacl_pkg::REG_WAYS:       ways_reg       <= cfg_data[sacl_pkg::WAYS_W-1:0];
                default:                  ;
            endcase
        end
    end

    // payload: hold the split address for both lookups of a beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg   <= set_calc;
            tag_reg   <= tag_calc;
            nw_m1_reg <= nw_m1_calc;
        end
        outcome_reg <= outcome_next;
        last_reg    <= last_next;
    end

    assign result_valid    = result_valid_reg;
    assign outcome         = outcome_reg;
    assign hits_total      = hit_cnt_reg;
    assign misses_total    = miss_cnt_reg;
    assign evictions_total = evict_cnt_reg;
    assign last_of_item    = last_reg;

    // ---------------- assertions ----------------
    `SACL_ASSERT_NXT(a_no_back_to_back, result_valid_reg, !result_valid_reg,
                     "results back to back")
    `SACL_ASSERT_NXT(a_busy_after_start, accept && (kind != sacl_pkg::KIND_FETCH), busy,
                     "lookup beat did not raise busy")
    `SACL_ASSERT_IMP(a_second_lookup_follows, result_valid_reg && !last_reg,
                     state_reg == ST_READ, "modify lost its second lookup")
    `SACL_ASSERT_IMP(a_hit_counted, result_valid_reg && (outcome_reg == sacl_pkg::OC_HIT),
                     hit_cnt_reg != '0, "hit reported with zero hit count")
    `SACL_ASSERT_IMP(a_evict_counted, result_valid_reg && (outcome_reg == sacl_pkg::OC_EVICT),
                     evict_cnt_reg != '0, "eviction reported with zero eviction count")

endmodule

[dv/set_assoc_cache_lru_sim_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_tb
// Self-checking bench for the cache tag and LRU model. A queue-fed driver
// issues trace accesses under several cache geometries. A monitor replays
// every accepted access on a local tag/age store and checks each lookup
// strobe field by field.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_tb;
    import sacl_pkg::*;

    localparam logic [1:0]           KIND_LOAD   = 2'd0;
    localparam logic [1:0]           KIND_STORE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam int                   N_LINES     = N_SETS * MAX_WAYS;
    localparam int                   SETTLE      = 40;
    localparam int                   STALL_LIMIT = 5000;
    localparam int                   PHASE_ITEMS = 150;

    typedef struct {
        logic [1:0]            kind;
        logic [ADDR_WIDTH-1:0] addr;
        bit                    drain;
    } access_t;

    typedef struct {
        logic [1:0]       outcome;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evicts;
        logic             last;
    } lookup_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              kind = KIND_LOAD;
    logic [ADDR_WIDTH-1:0]   address = '0;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    result_valid;
    logic [1:0]              outcome;
    logic [CNT_W-1:0]        hits_total;
    logic [CNT_W-1:0]        misses_total;
    logic [CNT_W-1:0]        evictions_total;
    logic                    last_of_item;

    // local copy of the tag store, counters and geometry
    logic                    way_valid [N_LINES];
    logic [ADDR_WIDTH-1:0]   way_tag   [N_LINES];
    logic [AGE_W-1:0]        way_age   [N_LINES];
    logic [CNT_W-1:0]        hit_cnt;
    logic [CNT_W-1:0]        miss_cnt;
    logic [CNT_W-1:0]        evict_cnt;
    logic [SB_W-1:0]         geo_set_bits;
    logic [BB_W-1:0]         geo_block_bits;
    logic [WAYS_W-1:0]       geo_ways;

    access_t                 pending_access_q [$];
    lookup_res_t             lookup_exp_q [$];
    int                      idle_pct   = 14;
    int                      issued_cnt = 0;
    int                      taken_cnt  = 0;
    int                      stall_cnt  = 0;
    int                      err_cnt    = 0;

    set_assoc_cache_lru_sim u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .address         (address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .outcome         (outcome),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total),
        .last_of_item    (last_of_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [AGE_W-1:0] bump_age(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? a : a + AGE_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    // One lookup on the local store; returns the outcome code.
    function automatic logic [1:0] lru_lookup(input logic [ADDR_WIDTH-1:0] addr);
        int                    sb;
        int                    nw;
        int                    bb;
        int                    sh;
        int                    base;
        int                    hw;
        int                    fw;
        int                    victim;
        logic [ADDR_WIDTH-1:0] set_idx;
        logic [ADDR_WIDTH-1:0] tg;
        logic [AGE_W-1:0]      hit_age;
        logic [AGE_W-1:0]      oldest;
        sb      = (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : geo_set_bits;
        nw      = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : geo_ways);
        bb      = geo_block_bits;
        sh      = sb + bb;
        set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
        tg      = (sh >= 64) ? '0 : (addr >> sh);
        base    = int'(set_idx) * MAX_WAYS;
        hw      = -1;
        for (int j = 0; j < nw; j++)
        begin
            if (hw < 0 && way_valid[base + j] && way_tag[base + j] == tg)
                hw = j;
        end
        if (hw >= 0)
        begin
            hit_cnt = count_up(hit_cnt);
            hit_age = way_age[base + hw];
            for (int j = 0; j < nw; j++)
            begin
                if (way_valid[base + j] && way_age[base + j] < hit_age)
                    way_age[base + j] = bump_age(way_age[base + j]);
            end
            way_age[base + hw] = '0;
            return OC_HIT;
        end
        miss_cnt = count_up(miss_cnt);
        // first free way wins; otherwise the oldest, highest way on ties
        fw     = -1;
        victim = 0;
        oldest = '0;
        for (int j = 0; j < nw; j++)
        begin
            if (fw < 0)
            begin
                if (!way_valid[base + j])
                    fw = j;
                else if (way_age[base + j] >= oldest)
                begin
                    oldest = way_age[base + j];
                    victim = j;
                end
            end
        end
        if (fw >= 0)
        begin
            for (int j = 0; j < nw; j++)
            begin
                if (way_valid[base + j])
                    way_age[base + j] = bump_age(way_age[base + j]);
            end
            way_valid[base + fw] = 1'b1;
            way_tag[base + fw]   = tg;
            way_age[base + fw]   = '0;
            return OC_FILL;
        end
        evict_cnt = count_up(evict_cnt);
        for (int j = 0; j < nw; j++)
            way_age[base + j] = bump_age(way_age[base + j]);
        way_tag[base + victim] = tg;
        way_age[base + victim] = '0;
        return OC_EVICT;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
            err_cnt++;
        end
    endtask

    task automatic queue_access(input logic [1:0] k, input logic [ADDR_WIDTH-1:0] a,
                                input bit drain);
        access_t acc;
        acc.kind  = k;
        acc.addr  = a;
        acc.drain = drain;
        pending_access_q.push_back(acc);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_access_q.size() != 0 || start || lookup_exp_q.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Program a geometry, then issue a batch of mostly conflicting accesses.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] sb_data,
                             input logic [CFG_DATA_W-1:0] bb_data,
                             input logic [CFG_DATA_W-1:0] ways_data, input int pct);
        int                    cnt;
        int                    nw;
        int                    sb;
        int                    bb;
        int                    sh;
        logic [1:0]            k;
        logic [ADDR_WIDTH-1:0] t;
        logic [ADDR_WIDTH-1:0] s;
        logic [ADDR_WIDTH-1:0] off;
        logic [ADDR_WIDTH-1:0] a;
        wait_idle();
        idle_pct = pct;
        cfg_write(REG_SET_BITS, sb_data);
        cfg_write(REG_BLOCK_BITS, bb_data);
        cfg_write(REG_WAYS, ways_data);
        @(posedge clk);
        sb  = (sb_data[3:0] > MAX_SET_BITS) ? MAX_SET_BITS : sb_data[3:0];
        nw  = (ways_data[3:0] == 0) ? 1
            : ((ways_data[3:0] > MAX_WAYS) ? MAX_WAYS : ways_data[3:0]);
        bb  = bb_data;
        sh  = sb + bb;
        cnt = 0;
        while (cnt < PHASE_ITEMS)
        begin
            k = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                a = {$urandom, $urandom};
            else
            begin
                // small tag and set pool so hits and evictions keep coming
                t   = $urandom_range(0, nw + 1);
                s   = $urandom_range(0, 1);
                off = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
                a   = (t << sh) | (s << bb) | off;
            end
            queue_access(k, a, cnt == 0 || $urandom_range(0, 39) == 0);
            cnt++;
        end
    endtask

    // Driver: hold start until the beat is taken, then advance or idle.
    always @(negedge clk)
    begin : drv
        access_t acc;
        if (!(start && taken_cnt != issued_cnt))
        begin
            if (rst_n && pending_access_q.size() != 0
                && $urandom_range(0, 99) >= idle_pct
                && !(pending_access_q[0].drain && (lookup_exp_q.size() != 0 || busy)))
            begin
                acc = pending_access_q.pop_front();
                kind    <= acc.kind;
                address <= acc.addr;
                start   <= 1'b1;
                issued_cnt++;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check result strobes, predict accepted accesses, track config beats.
    always @(posedge clk)
    begin : mon
        lookup_res_t e;
        bit          beat;
        int          n;
        beat = 1'b0;
        if (rst_n)
        begin
            if (result_valid)
            begin
                beat = 1'b1;
                if (lookup_exp_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual outcome %0d",
                             $time, outcome);
                    err_cnt++;
                end
                else
                begin
                    e = lookup_exp_q.pop_front();
                    check_field("outcome", e.outcome, outcome);
                    check_field("hits_total", e.hits, hits_total);
                    check_field("misses_total", e.misses, misses_total);
                    check_field("evictions_total", e.evicts, evictions_total);
                    check_field("last_of_item", e.last, last_of_item);
                end
            end
            if (start && !busy)
            begin
                beat = 1'b1;
                n = (kind == KIND_MODIFY) ? 2 : ((kind == KIND_FETCH) ? 0 : 1);
                for (int i = 0; i < n; i++)
                begin
                    e.outcome = lru_lookup(address);
                    e.hits    = hit_cnt;
                    e.misses  = miss_cnt;
                    e.evicts  = evict_cnt;
                    e.last    = (i == n - 1);
                    lookup_exp_q.push_back(e);
                end
                taken_cnt++;
            end
            if (cfg_valid && cfg_ready)
            begin
                beat = 1'b1;
                case (cfg_index)
                    REG_SET_BITS:   geo_set_bits   = cfg_data[SB_W-1:0];
                    REG_BLOCK_BITS: geo_block_bits = cfg_data[BB_W-1:0];
                    REG_WAYS:       geo_ways       = cfg_data[WAYS_W-1:0];
                    default:        ;
                endcase
            end
            stall_cnt = beat ? 0 : stall_cnt + 1;
        end
        else
        begin
            // mirror the reset state of the block
            hit_cnt        = '0;
            miss_cnt       = '0;
            evict_cnt      = '0;
            geo_set_bits   = 4'd4;
            geo_block_bits = 6'd4;
            geo_ways       = 4'd1;
            for (int i = 0; i < N_LINES; i++)
            begin
                way_valid[i] = 1'b0;
                way_tag[i]   = '0;
                way_age[i]   = '0;
            end
        end
    end

    initial
    begin : watchdog
        wait (stall_cnt >= STALL_LIMIT);
        $display("set_assoc_cache_lru_sim test failed");
        $finish;
    end

    initial
    begin : main
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_SET_BITS;
        cfg_data       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry, direct mapped: fill, hit, evict, modify, fetch, extremes
        queue_access(KIND_LOAD,   64'h0, 1'b0);
        queue_access(KIND_LOAD,   64'hF, 1'b0);
        queue_access(KIND_STORE,  64'h100, 1'b0);
        queue_access(KIND_MODIFY, 64'h200, 1'b0);
        queue_access(KIND_FETCH,  64'h100, 1'b0);
        queue_access(KIND_LOAD,   64'h200, 1'b0);
        queue_access(KIND_LOAD,   '1, 1'b0);
        queue_access(KIND_MODIFY, '1, 1'b0);
        queue_access(KIND_STORE,  64'h8000_0000_0000_0000, 1'b0);
        queue_access(KIND_LOAD,   64'h200, 1'b0);
        wait_idle();

        // one fully associative set of eight: fill all, touch way 0, evict LRU
        cfg_write(REG_SET_BITS, 6'd0);
        cfg_write(REG_BLOCK_BITS, 6'd0);
        cfg_write(REG_WAYS, 6'd8);
        @(posedge clk);
        for (int i = 0; i < 8; i++)
            queue_access(KIND_LOAD, 64'(i), 1'b0);
        queue_access(KIND_LOAD,   64'h0, 1'b0);
        queue_access(KIND_STORE,  64'h8, 1'b0);
        queue_access(KIND_MODIFY, 64'h1, 1'b0);
        queue_access(KIND_LOAD,   64'h0, 1'b0);

        run_phase(6'd3,  6'd6,  6'd4,  14);
        run_phase(6'd8,  6'd0,  6'd8,  14);
        run_phase(6'd15, 6'd32, 6'd0,  14);
        wait_idle();
        cfg_write(REG_UNUSED, 6'($urandom));
        run_phase(6'd1,  6'd63, 6'd15, 85);
        run_phase(6'd8,  6'd56, 6'd2,  85);
        run_phase(6'd0,  6'd5,  6'd3,  85);
        run_phase(6'd2,  6'd4,  6'd8,  0);
        run_phase(6'd9,  6'd12, 6'd6,  0);
        wait_idle();

        if (err_cnt == 0)
            $display("set_assoc_cache_lru_sim test passed");
        else
            $display("set_assoc_cache_lru_sim test failed");
        $finish;
    end

endmodule
